// ----- rtl/slr_pkg.sv -----
package slr_pkg;

    // Width of the step ratio register (unsigned Q4.16).
    localparam int STEP_W = 20;

    // Fraction bits of the step ratio and of the phase.
    localparam int FRAC_BITS = 16;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd2;

    // Step ratio after reset: one input frame per output frame.
    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    // At most this many results per input frame; the counter holds the cap itself.
    localparam int MAX_RESULTS = 24;
    localparam int CNT_W       = 5;

    // Control bits that travel with a frame from the front end to the back end.
    typedef struct packed {
        logic fin;
        logic byp;
    } t_cmd_ctl;

    // Control bits that travel with a result.
    typedef struct packed {
        logic eor;
        logic eot;
    } t_res_ctl;

endpackage

// ----- rtl/slr_fifo.sv -----
module slr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    // Two-entry register queue.
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ----- rtl/slr_front.sv -----
module slr_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [slr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Incoming frames.
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_in,
    input  logic                                   i_final_frame,
    // Command queue toward the back end.
    output logic [slr_pkg::STEP_W-1:0]             o_step,
    input  logic                                   i_cmd_pop,
    output logic                                   o_cmd_empty,
    output logic signed [SAMPLE_BITS-1:0]          o_cmd_left,
    output logic signed [SAMPLE_BITS-1:0]          o_cmd_right,
    output slr_pkg::t_cmd_ctl                      o_cmd_ctl
);

    localparam int CMD_W = 2 * SAMPLE_BITS + 2;

    logic [slr_pkg::STEP_W-1:0] r_step;
    logic                       r_mono;
    logic                       r_bypass;
    logic [SAMPLE_BITS-1:0]     w_right;
    slr_pkg::t_cmd_ctl          w_ctl;
    logic [CMD_W-1:0]           w_rdata;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign o_step    = r_step;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= slr_pkg::STEP_RESET;
            r_mono   <= 1'b0;
            r_bypass <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (i_cfg_index)
                slr_pkg::CFG_STEP:   r_step   <= i_cfg_data[slr_pkg::STEP_W-1:0];
                slr_pkg::CFG_MONO:   r_mono   <= i_cfg_data[0];
                slr_pkg::CFG_BYPASS: r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the frame: apply the mono copy and tag it with its handling.
    assign w_right   = r_mono ? i_left_in : i_right_in;
    assign w_ctl.fin = i_final_frame;
    assign w_ctl.byp = r_bypass;

    slr_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({i_left_in, w_right, w_ctl}),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_rdata (w_rdata),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd_left  = w_rdata[CMD_W-1 -: SAMPLE_BITS];
    assign o_cmd_right = w_rdata[2 +: SAMPLE_BITS];
    assign o_cmd_ctl   = slr_pkg::t_cmd_ctl'(w_rdata[1:0]);

endmodule

// ----- rtl/slr_back.sv -----
module slr_back #(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_UPSAMPLE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [slr_pkg::STEP_W-1:0]        i_step,
    // Command queue.
    output logic                              o_cmd_pop,
    input  logic                              i_cmd_empty,
    input  logic signed [SAMPLE_BITS-1:0]     i_cmd_left,
    input  logic signed [SAMPLE_BITS-1:0]     i_cmd_right,
    input  slr_pkg::t_cmd_ctl                 i_cmd_ctl,
    // Result queue.
    output logic                              o_res_push,
    input  logic                              i_res_full,
    output logic signed [SAMPLE_BITS-1:0]     o_res_left,
    output logic signed [SAMPLE_BITS-1:0]     o_res_right,
    output slr_pkg::t_res_ctl                 o_res_ctl
);

    localparam int FRAC_BITS = slr_pkg::FRAC_BITS;
    // Phase covers one frame plus one step.
    localparam int PHASE_W = ((FRAC_BITS + 1 > slr_pkg::STEP_W) ?
                              FRAC_BITS + 1 : slr_pkg::STEP_W) + 1;
    localparam int PROD_W  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [PHASE_W-1:0] ONE_Q    = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] MIN_STEP =
        PHASE_W'((64'd1 << FRAC_BITS) / MAX_UPSAMPLE);
    localparam logic [PROD_W-1:0]  HALF     = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [slr_pkg::CNT_W-1:0] CNT_MAX = slr_pkg::CNT_W'(slr_pkg::MAX_RESULTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [PHASE_W-1:0]           r_phase, n_phase;
    logic                         r_have_prev, n_have_prev;
    logic signed [SAMPLE_BITS-1:0] r_prev_l, n_prev_l;
    logic signed [SAMPLE_BITS-1:0] r_prev_r, n_prev_r;
    logic signed [SAMPLE_BITS-1:0] r_cur_l, n_cur_l;
    logic signed [SAMPLE_BITS-1:0] r_cur_r, n_cur_r;
    logic                         r_fin, n_fin;
    logic [slr_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_hold_v, n_hold_v;
    logic signed [SAMPLE_BITS-1:0] r_hold_l, n_hold_l;
    logic signed [SAMPLE_BITS-1:0] r_hold_r, n_hold_r;
    logic signed [PROD_W-1:0]     r_prod_l;
    logic signed [PROD_W-1:0]     r_prod_r;

    logic [PHASE_W-1:0]           w_step_raw;
    logic [PHASE_W-1:0]           w_step;
    logic signed [SAMPLE_BITS:0]  w_diff_l;
    logic signed [SAMPLE_BITS:0]  w_diff_r;
    logic signed [FRAC_BITS:0]    w_frac;
    logic signed [PROD_W-1:0]     w_rnd_l;
    logic signed [PROD_W-1:0]     w_rnd_r;
    logic signed [SAMPLE_BITS+1:0] w_sum_l;
    logic signed [SAMPLE_BITS+1:0] w_sum_r;
    logic                         w_can_emit;
    logic                         w_emit;
    logic signed [SAMPLE_BITS-1:0] w_emit_l;
    logic signed [SAMPLE_BITS-1:0] w_emit_r;

    // Steps below the upsampling limit act as the limit.
    assign w_step_raw = PHASE_W'(i_step);
    assign w_step     = (w_step_raw < MIN_STEP) ? MIN_STEP : w_step_raw;

    // Interpolation multiply stage: (cur - prev) * frac, registered.
    assign w_diff_l = {r_cur_l[SAMPLE_BITS-1], r_cur_l} - {r_prev_l[SAMPLE_BITS-1], r_prev_l};
    assign w_diff_r = {r_cur_r[SAMPLE_BITS-1], r_cur_r} - {r_prev_r[SAMPLE_BITS-1], r_prev_r};
    assign w_frac   = {1'b0, r_phase[FRAC_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod_l <= w_diff_l * w_frac;
            r_prod_r <= w_diff_r * w_frac;
        end
    end

    // Round half up, floor shift, then add back onto the previous sample.
    assign w_rnd_l = r_prod_l + HALF;
    assign w_rnd_r = r_prod_r + HALF;
    assign w_sum_l = {{2{r_prev_l[SAMPLE_BITS-1]}}, r_prev_l} + w_rnd_l[PROD_W-1:FRAC_BITS];
    assign w_sum_r = {{2{r_prev_r[SAMPLE_BITS-1]}}, r_prev_r} + w_rnd_r[PROD_W-1:FRAC_BITS];

    // A new result may enter the hold register if it is free or can move on.
    assign w_can_emit = !r_hold_v || !i_res_full;

    // Sequencer: one frame at a time; the last result waits in the hold
    // register until the end-of-run flag is known.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_have_prev = r_have_prev;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_hold_v    = r_hold_v;
        n_hold_l    = r_hold_l;
        n_hold_r    = r_hold_r;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res_left  = r_hold_l;
        o_res_right = r_hold_r;
        o_res_ctl   = '{eor: 1'b0, eot: 1'b0};
        w_emit      = 1'b0;
        w_emit_l    = r_cur_l;
        w_emit_r    = r_cur_r;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cur_l   = i_cmd_left;
                    n_cur_r   = i_cmd_right;
                    n_fin     = i_cmd_ctl.fin;
                    n_cnt     = '0;
                    if (i_cmd_ctl.byp) begin
                        n_hold_v    = 1'b1;
                        n_hold_l    = i_cmd_left;
                        n_hold_r    = i_cmd_right;
                        n_prev_l    = '0;
                        n_prev_r    = '0;
                        n_phase     = '0;
                        n_have_prev = 1'b0;
                        n_state     = S_DONE;
                    end else if (!r_have_prev) begin
                        n_phase     = '0;
                        n_have_prev = 1'b1;
                        n_prev_l    = i_cmd_left;
                        n_prev_r    = i_cmd_right;
                        n_state     = i_cmd_ctl.fin ? S_FIN : S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_phase < ONE_Q && r_cnt < CNT_MAX) begin
                    n_state = S_ADD;
                end else begin
                    n_phase  = (r_phase >= ONE_Q) ? r_phase - ONE_Q : '0;
                    n_prev_l = r_cur_l;
                    n_prev_r = r_cur_r;
                    n_state  = r_fin ? S_FIN : S_DONE;
                end
            end
            S_ADD: begin
                if (w_can_emit) begin
                    w_emit   = 1'b1;
                    w_emit_l = w_sum_l[SAMPLE_BITS-1:0];
                    w_emit_r = w_sum_r[SAMPLE_BITS-1:0];
                    n_cnt    = r_cnt + 1'b1;
                    n_phase  = r_phase + w_step;
                    n_state  = S_MUL;
                end
            end
            S_FIN: begin
                // Repeat the last frame up to one frame past it.
                if (r_phase <= ONE_Q && r_cnt < CNT_MAX) begin
                    if (w_can_emit) begin
                        w_emit  = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_phase = r_phase + w_step;
                    end
                end else begin
                    n_prev_l    = '0;
                    n_prev_r    = '0;
                    n_phase     = '0;
                    n_have_prev = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (r_hold_v) begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res_ctl  = '{eor: 1'b1, eot: r_fin};
                        n_hold_v   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A new result pushes the held one out to the result queue.
        if (w_emit) begin
            o_res_push = r_hold_v;
            n_hold_v   = 1'b1;
            n_hold_l   = w_emit_l;
            n_hold_r   = w_emit_r;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
            r_hold_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_have_prev <= n_have_prev;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_hold_v    <= n_hold_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur_l  <= n_cur_l;
        r_cur_r  <= n_cur_r;
        r_hold_l <= n_hold_l;
        r_hold_r <= n_hold_r;
    end

    // The hold register is drained before the next frame is taken.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("hold register occupied while idle");

    // The result count never passes the cap.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("result count past cap");

    // A result is only pushed when the result queue has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    // Interpolation only happens with the phase inside the current interval.
    a_add_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD |-> r_phase < ONE_Q)
        else $error("interpolation phase out of interval");

endmodule

// ----- rtl/stereo_linear_resampler_top.sv -----
// Results: a frame's results pass through the back-end sequencer and the hold register into the
// result queue; each result waits in the hold register until the next is made or the run ends.
// Flow: one frame at a time through the back-end sequencer; an interpolated result is multiplied
// in S_MUL, then rounded and added in S_ADD, and a repeated final result is made in S_FIN.
// Reset: i_rst_n is synchronous and active low; it empties both queues, clears the resampler
// state and returns the registers to step 1.0, stereo, no bypass.
module stereo_linear_resampler_top #(
    parameter int SAMPLE_BITS  = 24,
    parameter int MAX_UPSAMPLE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Frame input queue side.
    input  logic                              push,
    output logic                              full,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_in,
    input  logic                              i_final_frame,
    // Result queue side.
    output logic                              empty,
    input  logic                              pop,
    output logic signed [SAMPLE_BITS-1:0]     o_left_out,
    output logic signed [SAMPLE_BITS-1:0]     o_right_out,
    output logic                              o_end_of_run,
    output logic                              o_end_of_track
);

    localparam int RES_W = 2 * SAMPLE_BITS + 2;

    logic [slr_pkg::STEP_W-1:0]     w_step;
    logic                           w_cmd_pop;
    logic                           w_cmd_empty;
    logic signed [SAMPLE_BITS-1:0]  w_cmd_left;
    logic signed [SAMPLE_BITS-1:0]  w_cmd_right;
    slr_pkg::t_cmd_ctl              w_cmd_ctl;
    logic                           w_res_push;
    logic                           w_res_full;
    logic signed [SAMPLE_BITS-1:0]  w_res_left;
    logic signed [SAMPLE_BITS-1:0]  w_res_right;
    slr_pkg::t_res_ctl              w_res_ctl;
    logic [RES_W-1:0]               w_res_rdata;
    slr_pkg::t_res_ctl              w_out_ctl;

    // Front end: registers, classification and the frame queue.
    slr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_left_in     (i_left_in),
        .i_right_in    (i_right_in),
        .i_final_frame (i_final_frame),
        .o_step        (w_step),
        .i_cmd_pop     (w_cmd_pop),
        .o_cmd_empty   (w_cmd_empty),
        .o_cmd_left    (w_cmd_left),
        .o_cmd_right   (w_cmd_right),
        .o_cmd_ctl     (w_cmd_ctl)
    );

    // Back end: phase sequencer and interpolation datapath.
    slr_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd_left  (w_cmd_left),
        .i_cmd_right (w_cmd_right),
        .i_cmd_ctl   (w_cmd_ctl),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full),
        .o_res_left  (w_res_left),
        .o_res_right (w_res_right),
        .o_res_ctl   (w_res_ctl)
    );

    // Result queue toward the consumer.
    slr_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata ({w_res_left, w_res_right, w_res_ctl}),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty)
    );

    assign o_left_out     = w_res_rdata[RES_W-1 -: SAMPLE_BITS];
    assign o_right_out    = w_res_rdata[2 +: SAMPLE_BITS];
    assign w_out_ctl      = slr_pkg::t_res_ctl'(w_res_rdata[1:0]);
    assign o_end_of_run   = w_out_ctl.eor;
    assign o_end_of_track = w_out_ctl.eot;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int SAMPLE_W     = 24;
    localparam int FRAC_W       = slr_pkg::FRAC_BITS;
    localparam int UPSAMPLE_MAX = 8;
    localparam int unsigned ONE_Q    = 1 << FRAC_W;
    localparam int unsigned MIN_STEP = ONE_Q / UPSAMPLE_MAX;
    localparam longint HALF_LSB      = longint'(ONE_Q >> 1);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_CYCLES = 30;

    localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       fin;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       eor;
        logic                       eot;
    } t_out_frame;

    // Block ports; the inputs driven here start at known values from time zero.
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [slr_pkg::CFG_IDX_W-1:0]       i_cfg_index   = slr_pkg::CFG_STEP;
    logic [slr_pkg::CFG_DATA_W-1:0]      i_cfg_data    = '0;
    logic                                push          = 1'b0;
    logic                                full;
    logic signed [SAMPLE_W-1:0]          i_left_in     = '0;
    logic signed [SAMPLE_W-1:0]          i_right_in    = '0;
    logic                                i_final_frame = 1'b0;
    logic                                empty;
    logic                                pop           = 1'b0;
    logic signed [SAMPLE_W-1:0]          o_left_out;
    logic signed [SAMPLE_W-1:0]          o_right_out;
    logic                                o_end_of_run;
    logic                                o_end_of_track;

    stereo_linear_resampler_top #(
        .SAMPLE_BITS (SAMPLE_W),
        .MAX_UPSAMPLE(UPSAMPLE_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_left_in     (i_left_in),
        .i_right_in    (i_right_in),
        .i_final_frame (i_final_frame),
        .empty         (empty),
        .pop           (pop),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out),
        .o_end_of_run  (o_end_of_run),
        .o_end_of_track(o_end_of_track)
    );

    // Stimulus and expectation stores.
    t_frame     pending_frames[$];
    t_out_frame resampled_q[$];
    int         frames_queued   = 0;
    int         frames_accepted = 0;
    int         error_count     = 0;
    int         cycle_count     = 0;
    logic       frame_taken     = 1'b0;

    // Idle control.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_active    = 1'b0;
    int   hold_count     = 0;

    // Shadow of the configuration and of the resampler state.
    logic [slr_pkg::STEP_W-1:0] step_cfg   = slr_pkg::STEP_RESET;
    logic                       mono_cfg   = 1'b0;
    logic                       bypass_cfg = 1'b0;
    logic signed [SAMPLE_W-1:0] prev_l     = '0;
    logic signed [SAMPLE_W-1:0] prev_r     = '0;
    int unsigned                phase_acc  = 0;
    logic                       holding_prev = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Linear interpolation with round-half-up, then floor of the scaled product.
    function automatic logic signed [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [SAMPLE_W-1:0] b,
                                                        input int unsigned frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac) + HALF_LSB;
        return SAMPLE_W'(longint'(a) + (prod >>> FRAC_W));
    endfunction

    // Works out every resampled frame that one accepted input frame produces.
    task automatic resample_frame(input t_frame f);
        logic signed [SAMPLE_W-1:0] cur_l;
        logic signed [SAMPLE_W-1:0] cur_r;
        int unsigned stp;
        t_out_frame  batch[$];
        cur_l = f.left;
        cur_r = mono_cfg ? f.left : f.right;
        stp   = (int'(step_cfg) < MIN_STEP) ? MIN_STEP : int'(step_cfg);
        if (bypass_cfg) begin
            batch.push_back('{cur_l, cur_r, 1'b1, f.fin});
            prev_l = '0; prev_r = '0; phase_acc = 0; holding_prev = 1'b0;
        end else begin
            if (!holding_prev) begin
                phase_acc    = 0;
                holding_prev = 1'b1;
            end else begin
                while (phase_acc < ONE_Q && batch.size() < slr_pkg::MAX_RESULTS) begin
                    batch.push_back('{lerp(prev_l, cur_l, phase_acc),
                                      lerp(prev_r, cur_r, phase_acc), 1'b0, 1'b0});
                    phase_acc += stp;
                end
                phase_acc = (phase_acc >= ONE_Q) ? phase_acc - ONE_Q : 0;
            end
            prev_l = cur_l;
            prev_r = cur_r;
            // The last frame of a track repeats until the position passes one frame beyond it.
            if (f.fin) begin
                while (phase_acc <= ONE_Q && batch.size() < slr_pkg::MAX_RESULTS) begin
                    batch.push_back('{cur_l, cur_r, 1'b0, 1'b0});
                    phase_acc += stp;
                end
                if (batch.size() > 0)
                    batch[batch.size()-1].eot = 1'b1;
                prev_l = '0; prev_r = '0; phase_acc = 0; holding_prev = 1'b0;
            end
            if (batch.size() > 0)
                batch[batch.size()-1].eor = 1'b1;
        end
        foreach (batch[k])
            resampled_q.push_back(batch[k]);
    endtask

    // Frame driver: acceptance and prediction at the rising edge.
    always @(posedge i_clk) begin
        frame_taken <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            resample_frame(pending_frames[0]);
            void'(pending_frames.pop_front());
            frames_accepted++;
        end
    end

    // Frame driver: offers the next frame at the falling edge, holding a stalled one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && !frame_taken)) begin
            if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                push          <= 1'b1;
                i_left_in     <= pending_frames[0].left;
                i_right_in    <= pending_frames[0].right;
                i_final_frame <= pending_frames[0].fin;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the input side backs up.
    always @(negedge i_clk) begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_active <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            hold_active <= 1'b0;
        end
    end

    // Result monitor: random pop at the falling edge.
    always @(negedge i_clk) begin
        pop <= i_rst_n && !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: each transfer is compared against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_frame want;
        t_out_frame got;
        if (i_rst_n && pop && !empty) begin
            got = '{o_left_out, o_right_out, o_end_of_run, o_end_of_track};
            if (resampled_q.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result: expected none, got L=%0d R=%0d eor=%b eot=%b",
                         $time, got.left, got.right, got.eor, got.eot);
            end else begin
                want = resampled_q.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display({"%0t ns: result mismatch: expected L=%0d R=%0d eor=%b eot=%b,",
                              " got L=%0d R=%0d eor=%b eot=%b"},
                             $time, want.left, want.right, want.eor, want.eot,
                             got.left, got.right, got.eor, got.eot);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stereo_linear_resampler_top verification failed");
            $finish;
        end
    end

    task automatic add_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                             input logic fin);
        pending_frames.push_back('{l, r, fin});
        frames_queued++;
    endtask

    // Waits until every frame is taken and every result has been checked, then lets the
    // block finish any frame that produces nothing.
    task automatic wait_drained();
        while (frames_accepted != frames_queued || resampled_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write transfer; the shadow copy follows it.
    task automatic write_reg(input logic [slr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid   = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            slr_pkg::CFG_STEP:   step_cfg   = val[slr_pkg::STEP_W-1:0];
            slr_pkg::CFG_MONO:   mono_cfg   = val[0];
            slr_pkg::CFG_BYPASS: bypass_cfg = val[0];
            default:    ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [slr_pkg::STEP_W-1:0] stp, input logic mono,
                              input logic byp);
        write_reg(slr_pkg::CFG_STEP, slr_pkg::CFG_DATA_W'(stp));
        write_reg(slr_pkg::CFG_MONO, slr_pkg::CFG_DATA_W'(mono));
        write_reg(slr_pkg::CFG_BYPASS, slr_pkg::CFG_DATA_W'(byp));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
        case ($urandom_range(7))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return last + SAMPLE_W'($urandom_range(200)) - SAMPLE_W'(100);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // A track of frames; an unterminated one runs on into whatever follows.
    task automatic queue_track(input int len, input bit terminate);
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        l = SAMPLE_W'($urandom);
        r = SAMPLE_W'($urandom);
        for (int k = 0; k < len; k++) begin
            l = pick_sample(l);
            r = pick_sample(r);
            add_frame(l, r, terminate && (k == len - 1));
        end
    endtask

    // New settings at an idle point, then a batch of random tracks.
    task automatic random_group(input int items);
        logic [slr_pkg::STEP_W-1:0] stp;
        int left_over;
        int len;
        wait_drained();
        case ($urandom_range(9))
            0:       stp = slr_pkg::STEP_W'($urandom_range(MIN_STEP - 1));
            1:       stp = '1;
            2:       stp = slr_pkg::STEP_W'($urandom_range(1048575, 131073));
            3:       stp = slr_pkg::STEP_RESET;
            default: stp = slr_pkg::STEP_W'($urandom_range(131072, 8192));
        endcase
        set_config(stp, 1'($urandom_range(1)), $urandom_range(5) == 0);
        left_over = items;
        while (left_over > 0) begin
            len = $urandom_range(10, 1);
            if (len > left_over)
                len = left_over;
            queue_track(len, $urandom_range(9) != 0);
            left_over -= len;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: full-scale swings at unity step in stereo.
        add_frame(S_MAX, S_MIN, 1'b0);
        add_frame(S_MIN, S_MAX, 1'b0);
        add_frame(24'd0, 24'd0, 1'b0);
        add_frame(24'hFFFFFF, 24'd1, 1'b0);
        add_frame(S_MAX, S_MIN, 1'b1);
        // A track that is a single final frame.
        add_frame(24'd12345, -24'sd54321, 1'b1);
        wait_drained();

        // Fractional step with interpolation across full-scale swings.
        set_config(20'd24576, 1'b0, 1'b0);
        add_frame(S_MIN, S_MAX, 1'b0);
        add_frame(S_MAX, S_MIN, 1'b0);
        add_frame(24'd100, -24'sd100, 1'b1);
        wait_drained();

        // Step of zero and just below the floor both act as the minimum step.
        write_reg(slr_pkg::CFG_STEP, '0);
        add_frame(24'd0, 24'd0, 1'b0);
        add_frame(S_MIN, S_MAX, 1'b1);
        wait_drained();
        write_reg(slr_pkg::CFG_STEP, slr_pkg::CFG_DATA_W'(MIN_STEP - 1));
        add_frame(24'd5, -24'sd7, 1'b0);
        add_frame(-24'sd3, 24'd3, 1'b1);
        wait_drained();

        // Largest step: the final frame lies past every output position.
        write_reg(slr_pkg::CFG_STEP, '1);
        add_frame(24'd1, 24'd2, 1'b0);
        add_frame(24'd3, 24'd4, 1'b0);
        add_frame(24'd5, 24'd6, 1'b1);
        wait_drained();

        // Mono copies left into right.
        set_config(20'd98304, 1'b1, 1'b0);
        add_frame(24'd1000, 24'd777, 1'b0);
        add_frame(-24'sd2000, S_MIN, 1'b0);
        add_frame(24'd3000, S_MAX, 1'b1);
        wait_drained();

        // Bypass, with and without the mono copy.
        write_reg(slr_pkg::CFG_BYPASS, slr_pkg::CFG_DATA_W'(1));
        add_frame(S_MAX, S_MIN, 1'b0);
        add_frame(24'hFFFFFF, 24'd0, 1'b1);
        wait_drained();
        write_reg(slr_pkg::CFG_MONO, '0);
        add_frame(S_MIN, S_MAX, 1'b1);
        wait_drained();
        write_reg(slr_pkg::CFG_BYPASS, '0);

        // Random phases with different idle patterns on each side.
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int g = 0; g < 3; g++)
                random_group(10);
        end

        // Back pressure: the receiver holds off while frames keep coming.
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(20'd16384, 1'b0, 1'b0);
        hold_req = 1'b1;
        for (int t = 0; t < 3; t++)
            queue_track(12, 1'b1);

        wait_drained();
        if (error_count == 0 && resampled_q.size() == 0) begin
            $display("stereo_linear_resampler_top verification clean");
        end else begin
            $display("stereo_linear_resampler_top verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/slr_pkg.sv
rtl/slr_fifo.sv
rtl/slr_front.sv
rtl/slr_back.sv
rtl/stereo_linear_resampler_top.sv
tb/sv/testbench.sv
